// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rc_pkg.sv -----
package rc_pkg;

   localparam int ValueWidth = 63;
   localparam int BaseWidth  = 7;
   localparam int MaxDigits  = 64;
   localparam int StoreDepth = 64;
   localparam int AddrWidth  = $clog2(StoreDepth);
   localparam int CountWidth = $clog2(MaxDigits + 1);
   localparam int DivBits    = 3;
   localparam int DivSteps   = ValueWidth / DivBits;
   localparam int StepWidth  = $clog2(DivSteps);

   localparam logic [BaseWidth-1:0] MinBase        = 7'd2;
   localparam logic [BaseWidth-1:0] InputBaseReset  = 7'd10;
   localparam logic [BaseWidth-1:0] OutputBaseReset = 7'd2;

   // register indexes
   localparam logic RegInputBase  = 1'b0;
   localparam logic RegOutputBase = 1'b1;

   typedef struct packed {
      logic acc_step;
      logic acc_clear;
      logic div_load;
      logic div_step;
      logic store_wr;
      logic rd_issue;
      logic out_err;
      logic out_digit;
   } rc_cmd_type;

   typedef struct packed {
      logic fin_err;
      logic q_zero;
      logic cnt_last;
      logic rd_last;
   } rc_status_type;

endpackage

// ----- rtl/core/rc_channels.sv -----
interface rc_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] digit_in;
   logic              final_digit;

   modport source (output valid, output digit_in, output final_digit, input ready);
   modport sink (input valid, input digit_in, input final_digit, output ready);
endinterface

interface rc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] digit_out;
   logic       end_of_run;
   logic       failed;
   logic [6:0] length_out;

   modport source (output valid, output digit_out, output end_of_run, output failed,
                   output length_out, input ready);
   modport sink (input valid, input digit_out, input end_of_run, input failed,
                 input length_out, output ready);
endinterface

// ----- rtl/core/radix_converter.sv -----
// radix_converter: integer base conversion
// req_chan carries one input digit per word, most significant first, in the
// radix held in register 0; final_digit marks the last digit of a number.
// rsp_chan returns the digits of the value in the radix of register 1, most
// significant first, length_out on every word and end_of_run on the last.
// A bad base, a digit out of range or a value above 2^63-1 gives a single
// word with failed set instead. csr_we/csr_index/csr_wdata write a register;
// write only while the block is idle. Each non-final digit is one 63x7
// multiply-add. The final digit starts a divider that yields three quotient
// bits per cycle; each output digit is divided out in DIV and written to the
// digit store in STORE. Once the quotient is zero, the digits are read back
// in READ and sent in EMIT, most significant first.
// A failed number returns its word the cycle after the final digit.
// The output word sits in a register: a stalled receiver holds it there and
// the block takes no new digit and emits nothing more until that word is
// taken. Reset (synchronous) clears the accumulator and flags, sets the
// bases to 10 and 2 and drops rsp_chan.valid; no clearing pass.
`include "assert_macros.svh"

module radix_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [rc_pkg::BaseWidth-1:0]    csr_wdata,
   rc_req_if.sink                          req_chan,
   rc_rsp_if.source                        rsp_chan
);

   rc_pkg::rc_cmd_type    cmd;
   rc_pkg::rc_status_type status;

   rc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .final_digit (req_chan.final_digit),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   rc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .digit_in   (req_chan.digit_in),
      .cmd        (cmd),
      .status     (status),
      .digit_out  (rsp_chan.digit_out),
      .end_of_run (rsp_chan.end_of_run),
      .failed     (rsp_chan.failed),
      .length_out (rsp_chan.length_out)
   );

   `RC_ASSERT_IMP(a_fail_word, clock, reset, rsp_chan.valid && rsp_chan.failed,
      rsp_chan.digit_out == '0 && rsp_chan.length_out == '0 && rsp_chan.end_of_run,
      "error word malformed")
   `RC_ASSERT_IMP(a_digit_len, clock, reset, rsp_chan.valid && !rsp_chan.failed,
      rsp_chan.length_out != '0, "digit word with zero length")
   `RC_ASSERT_NXT(a_busy_conv, clock, reset,
      req_chan.valid && req_chan.ready && req_chan.final_digit && !status.fin_err,
      !req_chan.ready, "input taken during conversion")
   `RC_ASSERT_NXT(a_last_flag, clock, reset, cmd.out_digit && status.rd_last,
      rsp_chan.valid && rsp_chan.end_of_run, "last digit without end_of_run")

endmodule

// ----- rtl/core/rc_dpath.sv -----
module rc_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [rc_pkg::BaseWidth-1:0]     csr_wdata,
   input  logic signed [7:0]                digit_in,
   input  rc_pkg::rc_cmd_type               cmd,
   output rc_pkg::rc_status_type            status,
   output logic [rc_pkg::BaseWidth-1:0]     digit_out,
   output logic                             end_of_run,
   output logic                             failed,
   output logic [rc_pkg::CountWidth-1:0]    length_out
);

   localparam int VW = rc_pkg::ValueWidth;
   localparam int BW = rc_pkg::BaseWidth;
   localparam int PW = rc_pkg::ValueWidth + rc_pkg::BaseWidth;

   logic [BW-1:0]                    in_base_ff, out_base_ff;
   logic [VW-1:0]                    acc_ff;
   logic                             bad_ff, ovf_ff;
   logic [VW-1:0]                    quo_ff;
   logic [BW-1:0]                    rem_ff;
   logic [rc_pkg::CountWidth-1:0]    cnt_ff;
   logic [rc_pkg::AddrWidth-1:0]     rd_ff;
   logic [BW-1:0]                    rd_data_ff;
   logic [BW-1:0]                    mem [rc_pkg::StoreDepth];
   logic [BW-1:0]                    digit_ff;
   logic                             end_ff, fail_ff;
   logic [rc_pkg::CountWidth-1:0]    len_ff;

   logic [7:0]    d_u;
   logic          bad_digit, can_acc, ovf_digit, bad_in, ovf_in;
   logic [PW-1:0] sum_w;
   logic [VW-1:0] acc_in;
   logic [VW-1:0] quo_in;
   logic [BW-1:0] rem_in;

   assign d_u       = $unsigned(digit_in);
   assign bad_digit = digit_in[7] || (d_u >= {1'b0, in_base_ff});
   assign can_acc   = (in_base_ff >= rc_pkg::MinBase) && !bad_ff && !ovf_ff && !bad_digit;
   assign sum_w     = PW'(acc_ff) * PW'(in_base_ff) + PW'(d_u);
   // anything above bit 62 means the value passed 2^63-1
   assign ovf_digit = |sum_w[PW-1:VW];
   assign bad_in    = bad_ff | bad_digit;
   assign ovf_in    = ovf_ff | (can_acc & ovf_digit);
   assign acc_in    = (can_acc && !ovf_digit) ? sum_w[VW-1:0] : acc_ff;

   assign status.fin_err  = (in_base_ff < rc_pkg::MinBase) || (out_base_ff < rc_pkg::MinBase)
                            || bad_in || ovf_in;
   assign status.q_zero   = (quo_ff == '0);
   assign status.cnt_last = (cnt_ff == rc_pkg::CountWidth'(rc_pkg::MaxDigits - 1));
   assign status.rd_last  = (rd_ff == '0);

   // restoring division, DivBits quotient bits per cycle
   always_comb begin
      logic [BW:0]   t;
      logic [VW-1:0] q;
      logic [BW-1:0] r;
      q = quo_ff;
      r = rem_ff;
      for (int i = 0; i < rc_pkg::DivBits; i++) begin
         t = {r, q[VW-1]};
         q = {q[VW-2:0], 1'b0};
         if (t >= {1'b0, out_base_ff}) begin
            t    = t - {1'b0, out_base_ff};
            q[0] = 1'b1;
         end
         r = t[BW-1:0];
      end
      quo_in = q;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_base_ff  <= rc_pkg::InputBaseReset;
         out_base_ff <= rc_pkg::OutputBaseReset;
      end else if (csr_we) begin
         case (csr_index)
            rc_pkg::RegInputBase:  in_base_ff  <= csr_wdata;
            rc_pkg::RegOutputBase: out_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (cmd.acc_step) begin
         if (cmd.acc_clear) begin
            acc_ff <= '0;
            bad_ff <= 1'b0;
            ovf_ff <= 1'b0;
         end else begin
            acc_ff <= acc_in;
            bad_ff <= bad_in;
            ovf_ff <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= acc_in;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end else if (cmd.store_wr) begin
         rem_ff <= '0;
         cnt_ff <= cnt_ff + 1'b1;
         rd_ff  <= cnt_ff[rc_pkg::AddrWidth-1:0];
      end else if (cmd.out_digit) begin
         rd_ff  <= rd_ff - 1'b1;
      end
   end

   // digit store, filled least significant first
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         mem[cnt_ff[rc_pkg::AddrWidth-1:0]] <= rem_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_err) begin
         digit_ff <= '0;
         end_ff   <= 1'b1;
         fail_ff  <= 1'b1;
         len_ff   <= '0;
      end else if (cmd.out_digit) begin
         digit_ff <= rd_data_ff;
         end_ff   <= status.rd_last;
         fail_ff  <= 1'b0;
         len_ff   <= cnt_ff;
      end
   end

   assign digit_out  = digit_ff;
   assign end_of_run = end_ff;
   assign failed     = fail_ff;
   assign length_out = len_ff;

endmodule

// ----- rtl/core/rc_ctrl.sv -----
module rc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  final_digit,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rc_pkg::rc_status_type status,
   output rc_pkg::rc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DIV,
      STORE,
      READ,
      EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [rc_pkg::StepWidth-1:0]  step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_free, accept;

   // output register can take a new word this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.acc_step = 1'b1;
               if (final_digit) begin
                  cmd.acc_clear = 1'b1;
                  if (status.fin_err) begin
                     cmd.out_err  = 1'b1;
                     out_valid_in = 1'b1;
                  end else begin
                     cmd.div_load = 1'b1;
                     step_in      = '0;
                     state_in     = DIV;
                  end
               end
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == rc_pkg::StepWidth'(rc_pkg::DivSteps - 1)) begin
               state_in = STORE;
            end
         end
         STORE: begin
            cmd.store_wr = 1'b1;
            if (status.q_zero || status.cnt_last) begin
               state_in = READ;
            end else begin
               step_in  = '0;
               state_in = DIV;
            end
         end
         READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = EMIT;
         end
         EMIT: begin
            if (out_free) begin
               cmd.out_digit = 1'b1;
               out_valid_in  = 1'b1;
               state_in      = status.rd_last ? IDLE : READ;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- verif/tb_radix_converter.sv -----
module tb_radix_converter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned ValueLimit = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned PastLimit  = 64'h8000_0000_0000_0000;
   localparam int MaxBase      = 2**rc_pkg::BaseWidth - 1;
   localparam int StallLimit   = 20000;
   localparam int SettleCycles = 30;
   localparam int DrainCycles  = 200;

   typedef struct packed {
      logic [6:0] digit;
      logic       last;
      logic       failed;
      logic [6:0] length;
   } conv_word_type;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         csr_we    = 1'b0;
   logic                         csr_index = rc_pkg::RegInputBase;
   logic [rc_pkg::BaseWidth-1:0] csr_wdata = '0;

   rc_req_if req_if();
   rc_rsp_if rsp_if();

   radix_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // converter state as seen from outside
   logic [rc_pkg::BaseWidth-1:0] in_base  = rc_pkg::InputBaseReset;
   logic [rc_pkg::BaseWidth-1:0] out_base = rc_pkg::OutputBaseReset;
   longint unsigned      acc_value = 0;
   bit                   bad_digit = 1'b0;
   bit                   overflow  = 1'b0;
   conv_word_type        expected_words[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int digits_sent    = 0;
   int numbers_sent   = 0;
   int words_seen     = 0;
   int error_words    = 0;
   int base_settings  = 0;
   int fails          = 0;
   int quiet_cycles   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void predict_digit(input logic [7:0] raw, input logic fin);
      longint unsigned d;
      longint unsigned ib;
      longint unsigned ob;
      longint unsigned v;
      logic [6:0]      digs[rc_pkg::MaxDigits];
      int              count;
      d  = raw;
      ib = in_base;
      ob = out_base;
      if (raw[7] || d >= ib) begin
         bad_digit = 1'b1;
      end else if (ib >= 2 && !bad_digit && !overflow) begin
         if (acc_value > (ValueLimit - d) / ib) begin
            overflow = 1'b1;
         end else begin
            acc_value = acc_value * ib + d;
         end
      end
      if (!fin) return;
      if (ib < 2 || ob < 2 || bad_digit || overflow) begin
         expected_words.push_back('{7'd0, 1'b1, 1'b1, 7'd0});
      end else begin
         v = acc_value;
         count = 0;
         do begin
            digs[count] = 7'(v % ob);
            v = v / ob;
            count++;
         end while (v != 0 && count < rc_pkg::MaxDigits);
         for (int k = count - 1; k >= 0; k--) begin
            expected_words.push_back('{digs[k], (k == 0), 1'b0, 7'(count)});
         end
      end
      acc_value = 0;
      bad_digit = 1'b0;
      overflow  = 1'b0;
   endfunction

   // digits of a value in a base, most significant first
   function automatic void value_digits(input longint unsigned value, input int base,
                                        ref logic [7:0] digs[$]);
      longint unsigned v;
      longint unsigned b;
      v = value;
      b = base;
      digs.delete();
      do begin
         digs.push_front(8'(v % b));
         v = v / b;
      end while (v != 0);
   endfunction

   function automatic int random_base();
      case ($urandom_range(15))
         0: begin
            return $urandom_range(1);
         end
         1, 2: begin
            return rc_pkg::MinBase;
         end
         3, 4: begin
            return MaxBase;
         end
         default: begin
            return $urandom_range(MaxBase, rc_pkg::MinBase);
         end
      endcase
   endfunction

   task automatic send_digit(input logic [7:0] raw, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.digit_in    <= raw;
      req_if.final_digit <= fin;
      do @(posedge clock); while (!req_if.ready);
      predict_digit(raw, fin);
      digits_sent++;
   endtask

   task automatic send_number(ref logic [7:0] digs[$]);
      foreach (digs[i]) begin
         send_digit(digs[i], i == digs.size() - 1);
      end
      numbers_sent++;
   endtask

   // hold the sender until every expected word is back, then let the block settle
   task automatic drain_words();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [rc_pkg::BaseWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == rc_pkg::RegInputBase) begin
         in_base = value;
      end else begin
         out_base = value;
      end
   endtask

   task automatic set_bases(input int ib, input int ob);
      drain_words();
      write_reg(rc_pkg::RegInputBase, rc_pkg::BaseWidth'(ib));
      write_reg(rc_pkg::RegOutputBase, rc_pkg::BaseWidth'(ob));
      base_settings++;
   endtask

   task automatic send_random_number();
      logic [7:0] digs[$];
      int         ib;
      int         kind;
      int         len;
      int         fit;
      int         pos;
      ib   = in_base;
      kind = $urandom_range(9);
      if (ib < 2 || kind == 9) begin
         // noise: any byte, negatives included
         len = $urandom_range(4, 1);
         repeat (len) digs.push_back(8'($urandom_range(255)));
      end else begin
         value_digits(ValueLimit, ib, digs);
         fit = digs.size();
         digs.delete();
         if ($urandom_range(3) == 0) begin
            len = $urandom_range(fit + 1, fit - 1);
         end else begin
            len = $urandom_range((fit < 8) ? fit : 8, 1);
         end
         repeat (len) begin
            digs.push_back((kind == 7) ? 8'd0 : 8'($urandom_range(ib - 1)));
         end
         if (kind == 8) begin
            pos = $urandom_range(len - 1);
            digs[pos] = 8'($urandom_range(255, ib));
         end
      end
      send_number(digs);
   endtask

   task automatic run_random_numbers(input int n_items);
      int target;
      target = digits_sent + n_items;
      while (digits_sent < target) begin
         set_bases(random_base(), random_base());
         repeat ($urandom_range(8, 2)) send_random_number();
      end
   endtask

   // reset bases, a zero value gives one digit
   task automatic test_zero_value();
      logic [7:0] digs[$];
      digs = '{8'd0};
      send_number(digs);
   endtask

   // largest legal value gives the longest run, one more overflows
   task automatic test_value_extremes();
      logic [7:0] digs[$];
      set_bases(MaxBase, rc_pkg::MinBase);
      value_digits(ValueLimit, MaxBase, digs);
      send_number(digs);
      value_digits(PastLimit, MaxBase, digs);
      send_number(digs);
   endtask

   task automatic test_bad_digits();
      logic [7:0] digs[$];
      set_bases(MaxBase, MaxBase);
      digs = '{8'h80};
      send_number(digs);
      digs = '{8'(MaxBase), 8'd5};
      send_number(digs);
      // converter re-arms after an error word
      digs = '{8'(MaxBase - 1)};
      send_number(digs);
   endtask

   task automatic test_low_bases();
      logic [7:0] digs[$];
      digs = '{8'd0};
      set_bases(1, 10);
      send_number(digs);
      set_bases(0, 10);
      send_number(digs);
      digs = '{8'd5};
      set_bases(10, 0);
      send_number(digs);
      set_bases(10, 1);
      send_number(digs);
   endtask

   task automatic test_base_change_mid_number();
      set_bases(2, 10);
      send_digit(8'd1, 1'b0);
      send_digit(8'd0, 1'b0);
      drain_words();
      write_reg(rc_pkg::RegInputBase, rc_pkg::BaseWidth'(16));
      base_settings++;
      send_digit(8'd15, 1'b1);
      numbers_sent++;
   endtask

   task automatic test_random_slow_receiver();
      send_idle_pct  = 18;
      recv_stall_pct = 85;
      run_random_numbers(150);
   endtask

   task automatic test_random_slow_sender();
      send_idle_pct  = 85;
      recv_stall_pct = 18;
      run_random_numbers(150);
   endtask

   task automatic test_random_full_rate();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_numbers(150);
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      conv_word_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: digit_out %0d failed %0b", rsp_if.digit_out,
                      rsp_if.failed);
               fails++;
            end else begin
               want = expected_words.pop_front();
               if (want.failed) error_words++;
               if (rsp_if.digit_out !== want.digit) begin
                  $error("digit_out: expected %0d, got %0d", want.digit, rsp_if.digit_out);
                  fails++;
               end
               if (rsp_if.end_of_run !== want.last) begin
                  $error("end_of_run: expected %0b, got %0b", want.last, rsp_if.end_of_run);
                  fails++;
               end
               if (rsp_if.failed !== want.failed) begin
                  $error("failed: expected %0b, got %0b", want.failed, rsp_if.failed);
                  fails++;
               end
               if (rsp_if.length_out !== want.length) begin
                  $error("length_out: expected %0d, got %0d", want.length,
                         rsp_if.length_out);
                  fails++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("stalled for %0d cycles with %0d words outstanding", quiet_cycles,
                     expected_words.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.digit_in    = '0;
      req_if.final_digit = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 18;
      recv_stall_pct = 85;
      test_zero_value();
      test_value_extremes();
      test_bad_digits();
      test_low_bases();
      test_base_change_mid_number();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_full_rate();

      drain_words();
      repeat (DrainCycles) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         fails++;
      end
      $display("converted %0d numbers from %0d digits into %0d words (%0d error words)",
               numbers_sent, digits_sent, words_seen, error_words);
      $display("over %0d base settings, with sender and receiver idling in turn",
               base_settings);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rc_pkg.sv
rtl/core/rc_channels.sv
rtl/core/rc_dpath.sv
rtl/core/rc_ctrl.sv
rtl/core/radix_converter.sv
verif/tb_radix_converter.sv
